@@ rtl/core/csp_pkg.sv @@
package csp_pkg;

  // Curve geometry and field widths
  localparam int MAX_SEGMENTS = 32;
  localparam int SEG_W        = 6;
  localparam int COORD_W      = 16;
  localparam int DIFF_W       = 17;
  localparam int CURV_W       = 16;
  localparam int S_W          = 17;
  localparam int H_W          = 20;
  localparam int P01_W        = 37;
  localparam int P23_W        = 38;
  localparam int ACC_W        = 56;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [SEG_W-1:0]  SEG_RESET  = 6'd8;
  localparam logic [CURV_W-1:0] CURV_RESET = 16'd8192;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEGMENT_COUNT = 1'b0,
    REG_CURVATURE     = 1'b1
  } cfg_reg_t;

  // One beat of control points
  typedef struct packed {
    logic signed [COORD_W-1:0] p0_x;
    logic signed [COORD_W-1:0] p0_y;
    logic signed [COORD_W-1:0] p0_z;
    logic signed [COORD_W-1:0] p1_x;
    logic signed [COORD_W-1:0] p1_y;
    logic signed [COORD_W-1:0] p1_z;
    logic signed [COORD_W-1:0] p2_x;
    logic signed [COORD_W-1:0] p2_y;
    logic signed [COORD_W-1:0] p2_z;
    logic signed [COORD_W-1:0] p3_x;
    logic signed [COORD_W-1:0] p3_y;
    logic signed [COORD_W-1:0] p3_z;
  } in_item_t;

  // One beat of curve output
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      last;
  } out_item_t;

  // Per-axis operands after classification: endpoints and tangent differences
  typedef struct packed {
    logic signed [COORD_W-1:0] p1;
    logic signed [COORD_W-1:0] p2;
    logic signed [DIFF_W-1:0]  d1;
    logic signed [DIFF_W-1:0]  d2;
  } axis_t;

  typedef struct packed {
    axis_t [2:0] ax;
  } work_t;

  // Parameter step per index: 65536 = STEP_Q[n] * n + STEP_R[n]
  localparam logic [S_W-1:0] STEP_Q [0:MAX_SEGMENTS] = '{
    17'd0,
    17'(65536/1),  17'(65536/2),  17'(65536/3),  17'(65536/4),
    17'(65536/5),  17'(65536/6),  17'(65536/7),  17'(65536/8),
    17'(65536/9),  17'(65536/10), 17'(65536/11), 17'(65536/12),
    17'(65536/13), 17'(65536/14), 17'(65536/15), 17'(65536/16),
    17'(65536/17), 17'(65536/18), 17'(65536/19), 17'(65536/20),
    17'(65536/21), 17'(65536/22), 17'(65536/23), 17'(65536/24),
    17'(65536/25), 17'(65536/26), 17'(65536/27), 17'(65536/28),
    17'(65536/29), 17'(65536/30), 17'(65536/31), 17'(65536/32)
  };

  localparam logic [4:0] STEP_R [0:MAX_SEGMENTS] = '{
    5'd0,
    5'(65536%1),  5'(65536%2),  5'(65536%3),  5'(65536%4),
    5'(65536%5),  5'(65536%6),  5'(65536%7),  5'(65536%8),
    5'(65536%9),  5'(65536%10), 5'(65536%11), 5'(65536%12),
    5'(65536%13), 5'(65536%14), 5'(65536%15), 5'(65536%16),
    5'(65536%17), 5'(65536%18), 5'(65536%19), 5'(65536%20),
    5'(65536%21), 5'(65536%22), 5'(65536%23), 5'(65536%24),
    5'(65536%25), 5'(65536%26), 5'(65536%27), 5'(65536%28),
    5'(65536%29), 5'(65536%30), 5'(65536%31), 5'(65536%32)
  };

  // Output queue in the point engine
  localparam int OFIFO_DEPTH = 16;
  localparam int OFIFO_AW    = 4;
  localparam int OFIFO_CW    = 5;

endpackage

@@ rtl/core/csp_front.sv @@
module csp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  csp_pkg::in_item_t in_item,
  output logic              in_full,
  output csp_pkg::work_t    wq_head,
  output logic              wq_valid,
  input  logic              wq_pop
);
  import csp_pkg::*;

  work_t      mem_r [0:1];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;
  logic       pop;
  work_t      entry;

  // Classify: keep endpoints, form tangent differences
  always_comb begin
    entry.ax[0].p1 = in_item.p1_x;
    entry.ax[0].p2 = in_item.p2_x;
    entry.ax[0].d1 = DIFF_W'(in_item.p2_x) - DIFF_W'(in_item.p0_x);
    entry.ax[0].d2 = DIFF_W'(in_item.p3_x) - DIFF_W'(in_item.p1_x);
    entry.ax[1].p1 = in_item.p1_y;
    entry.ax[1].p2 = in_item.p2_y;
    entry.ax[1].d1 = DIFF_W'(in_item.p2_y) - DIFF_W'(in_item.p0_y);
    entry.ax[1].d2 = DIFF_W'(in_item.p3_y) - DIFF_W'(in_item.p1_y);
    entry.ax[2].p1 = in_item.p1_z;
    entry.ax[2].p2 = in_item.p2_z;
    entry.ax[2].d1 = DIFF_W'(in_item.p2_z) - DIFF_W'(in_item.p0_z);
    entry.ax[2].d2 = DIFF_W'(in_item.p3_z) - DIFF_W'(in_item.p1_z);
  end

  assign in_full  = (cnt_r == 2'd2);
  assign push     = in_push && !in_full;
  assign pop      = wq_pop;
  assign wq_valid = (cnt_r != 2'd0);
  assign wq_head  = mem_r[rd_ptr_r];

  // Advance queue pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // Hold classified beats
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= entry;
  end

endmodule

@@ rtl/core/csp_back.sv @@
module csp_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [csp_pkg::SEG_W-1:0]  seg_count,
  input  logic [csp_pkg::CURV_W-1:0] curvature,
  input  csp_pkg::work_t             wq_head,
  input  logic                       wq_valid,
  output logic                       wq_pop,
  input  logic                       out_pop,
  output logic                       out_empty,
  output csp_pkg::out_item_t         out_item
);
  import csp_pkg::*;

  // Sequencer state
  logic                   busy_r;
  work_t                  cur_r;
  logic [SEG_W-1:0]       n_r;
  logic [CURV_W-1:0]      curv_r;
  logic [SEG_W-1:0]       k_r;
  logic [S_W-1:0]         q_r;
  logic [4:0]             rem_r;
  logic [OFIFO_CW-1:0]    credit_r;
  logic [OFIFO_CW-1:0]    credit_nxt;

  logic [SEG_W-1:0]       n_eff;
  logic                   start;
  logic                   issue;
  logic                   is_last;
  logic [S_W-1:0]         stq;
  logic [4:0]             str;
  logic [SEG_W-1:0]       rsum;
  logic                   wrap;

  // Point pipeline
  logic [6:1]             v_r;
  logic [6:1]             last_r;
  logic [S_W-1:0]         s1_r;
  logic [S_W-1:0]         s2_a_r;
  logic [S_W-1:0]         s2_b_r;
  logic [S_W-1:0]         s3_a_r;
  logic [S_W-1:0]         s3_b_r;
  logic [S_W-1:0]         s3_c_r;
  logic signed [H_W-1:0]  h_r [0:3];
  logic signed [P01_W-1:0] m01_r [0:2];
  logic signed [P23_W-1:0] m23_r [0:2];
  logic signed [ACC_W-1:0] acc_r [0:2];
  logic [2*S_W:0]         sq_full;
  logic [2*S_W:0]         cu_full;
  logic signed [H_W-1:0]  ea;
  logic signed [H_W-1:0]  eb;
  logic signed [H_W-1:0]  ec;

  // Output queue
  out_item_t              mem_r [0:OFIFO_DEPTH-1];
  logic [OFIFO_AW-1:0]    wr_ptr_r;
  logic [OFIFO_AW-1:0]    rd_ptr_r;
  logic [OFIFO_CW-1:0]    cnt_r;
  logic                   pop;
  out_item_t              wdata;

  // Round half up by 2^30, then clamp to 16 bits
  function automatic logic signed [COORD_W-1:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] w;
    logic signed [ACC_W-1:0] sh;
    w  = a + $signed({{(ACC_W-30){1'b0}}, 1'b1, 29'b0});
    sh = w >>> 30;
    if (sh > $signed(ACC_W'(32767)))       return 16'sh7fff;
    else if (sh < -$signed(ACC_W'(32768))) return 16'sh8000;
    else                                   return sh[COORD_W-1:0];
  endfunction

  // Clamp segment count to 1..MAX_SEGMENTS
  always_comb begin
    if (seg_count == '0)                        n_eff = SEG_W'(1);
    else if (seg_count > SEG_W'(MAX_SEGMENTS)) n_eff = SEG_W'(MAX_SEGMENTS);
    else                                        n_eff = seg_count;
  end

  assign start       = !busy_r && wq_valid && !(v_r[1] | v_r[2] | v_r[3] | v_r[4]);
  assign wq_pop      = start;
  assign issue       = busy_r && (credit_r != '0);
  assign is_last     = ({1'b0, k_r} == ({n_r, 1'b0} - 7'd1));
  assign stq         = STEP_Q[n_r];
  assign str         = STEP_R[n_r];
  assign rsum        = {1'b0, rem_r} + {1'b0, str};
  assign wrap        = (rsum >= n_r);
  assign pop         = out_pop && !out_empty;
  assign credit_nxt  = credit_r - OFIFO_CW'(issue) + OFIFO_CW'(pop);

  // Hold busy flag, valid pipe, credits and queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      v_r      <= '0;
      credit_r <= OFIFO_CW'(OFIFO_DEPTH);
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (start)                busy_r <= 1'b1;
      else if (issue && is_last) busy_r <= 1'b0;
      v_r      <= {v_r[5:1], issue};
      credit_r <= credit_nxt;
      if (v_r[6]) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)    rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + OFIFO_CW'(v_r[6]) - OFIFO_CW'(pop);
    end
  end

  // Load a control point set, then step the parameter s = round(65536*j/N) exactly
  always_ff @(posedge clk) begin
    if (start) begin
      cur_r  <= wq_head;
      n_r    <= n_eff;
      curv_r <= curvature;
      k_r    <= '0;
      q_r    <= '0;
      rem_r  <= n_eff[5:1];
    end else if (issue) begin
      k_r <= k_r + 1'b1;
      if (!k_r[0]) begin
        if (wrap) begin
          q_r   <= q_r + stq + 1'b1;
          rem_r <= 5'(rsum - n_r);
        end else begin
          q_r   <= q_r + stq;
          rem_r <= rsum[4:0];
        end
      end
    end
  end

  assign sq_full = (2*S_W+1)'(s1_r) * (2*S_W+1)'(s1_r) + (2*S_W+1)'(32768);
  assign cu_full = (2*S_W+1)'(s2_b_r) * (2*S_W+1)'(s2_a_r) + (2*S_W+1)'(32768);
  assign ea      = $signed(H_W'(s3_a_r));
  assign eb      = $signed(H_W'(s3_b_r));
  assign ec      = $signed(H_W'(s3_c_r));

  // Advance points: s, s^2, s^3, basis, partial sums, accumulate
  always_ff @(posedge clk) begin
    last_r <= {last_r[5:1], is_last};
    s1_r   <= q_r;
    s2_a_r <= s1_r;
    s2_b_r <= sq_full[S_W+15:16];
    s3_a_r <= s2_a_r;
    s3_b_r <= s2_b_r;
    s3_c_r <= cu_full[S_W+15:16];
    h_r[0] <= H_W'(2*ec - 3*eb + H_W'(65536));
    h_r[1] <= H_W'(3*eb - 2*ec);
    h_r[2] <= H_W'(ec - 2*eb + ea);
    h_r[3] <= H_W'(ec - eb);
    for (int a = 0; a < 3; a++) begin
      m01_r[a] <= P01_W'(h_r[0]) * P01_W'(cur_r.ax[a].p1)
                + P01_W'(h_r[1]) * P01_W'(cur_r.ax[a].p2);
      m23_r[a] <= P23_W'(h_r[2]) * P23_W'(cur_r.ax[a].d1)
                + P23_W'(h_r[3]) * P23_W'(cur_r.ax[a].d2);
      acc_r[a] <= (ACC_W'(m01_r[a]) <<< 14)
                + ACC_W'(m23_r[a]) * ACC_W'($signed({1'b0, curv_r}));
    end
  end

  assign wdata.x    = round_sat(acc_r[0]);
  assign wdata.y    = round_sat(acc_r[1]);
  assign wdata.z    = round_sat(acc_r[2]);
  assign wdata.last = last_r[6];

  // Hold finished beats until popped
  always_ff @(posedge clk) begin
    if (v_r[6]) mem_r[wr_ptr_r] <= wdata;
  end

  assign out_empty = (cnt_r == '0);
  assign out_item  = mem_r[rd_ptr_r];

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, credit_r} + {1'b0, cnt_r}) <= (OFIFO_CW+1)'(OFIFO_DEPTH))
    else $error("credits and queue level exceed queue depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[6] |-> (cnt_r < OFIFO_CW'(OFIFO_DEPTH)))
    else $error("point written into a full output queue");

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && is_last) |=> !busy_r)
    else $error("sequencer still busy after last point");

  a_load_clear: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> (k_r == '0) && busy_r && !v_r[1])
    else $error("new point set loaded with stale sequencer state");

endmodule

@@ rtl/core/cardinal_spline_segment_points_top.sv @@
// Cardinal spline point generator. Push one set of four 3D control points (signed Q8.8);
// the block pops out 2*N curve points, the start and end of each of N segments between p1
// and p2, with last set on the final one. N comes from segment_count (0 acts as 1, values
// above 32 act as 32) and the tangent scale from curvature (Q2.14). Points leave one per
// cycle while output credits remain, from a shared six-stage basis/multiply pipeline;
// the next set loads once the last point has issued and the early stages have drained.
// A two-entry queue takes input sets while points are produced, and a 16-entry output
// queue absorbs stalls on the result side. Write configuration only while idle.
module cardinal_spline_segment_points_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  input  csp_pkg::in_item_t              in_item,
  output logic                           in_full,
  output logic                           out_empty,
  input  logic                           out_pop,
  output csp_pkg::out_item_t             out_item,
  input  logic                           cfg_we,
  input  logic [csp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [csp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import csp_pkg::*;

  logic [SEG_W-1:0]  seg_count_r;
  logic [CURV_W-1:0] curvature_r;
  work_t             wq_head;
  logic              wq_valid;
  logic              wq_pop;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_count_r <= SEG_RESET;
      curvature_r <= CURV_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SEGMENT_COUNT: seg_count_r <= cfg_data[SEG_W-1:0];
        REG_CURVATURE:     curvature_r <= cfg_data[CURV_W-1:0];
      endcase
    end
  end

  csp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_item  (in_item),
    .in_full  (in_full),
    .wq_head  (wq_head),
    .wq_valid (wq_valid),
    .wq_pop   (wq_pop)
  );

  csp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .seg_count (seg_count_r),
    .curvature (curvature_r),
    .wq_head   (wq_head),
    .wq_valid  (wq_valid),
    .wq_pop    (wq_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

endmodule
